// ----- rtl/core/esc_pkg.sv -----
`default_nettype none

package esc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LOW  = 3'd1,
        CFG_PRESS_HIGH = 3'd2,
        CFG_PRESS_LAST = 3'd3,
        CFG_HUM        = 3'd4
    } t_cfg_reg;

    // Pipeline stage numbers
    localparam int ST_TEMP   = 4;
    localparam int ST_HUM    = 16;
    localparam int ST_DIV0   = 10;
    localparam int DIV_STEPS = 41;
    localparam int LAT       = ST_DIV0 + DIV_STEPS + 5;

    // Divider widths: divisor/remainder and quotient
    localparam int DEN_W = 57;
    localparam int QUO_W = DIV_STEPS;

    // One stage of the pressure divider
    typedef struct packed {
        logic             ovf;
        logic             bad;
        logic             xneg;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] lq;
    } t_div_stage;

endpackage

`default_nettype wire

// ----- rtl/core/env_sensor_compensation.sv -----
// Throughput: one reading per cycle while the output is not stalled; the
// pressure divider is 41 pipelined stages, one quotient bit per stage, and the
// whole pipeline advances together.
// A stall at the output holds every stage; no item is lost or repeated.
// Reset clears the stage valid bits and all calibration registers to zero.
`default_nettype none

module env_sensor_compensation (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [19:0]        i_raw_temperature,
    input  wire logic [19:0]        i_raw_pressure,
    input  wire logic [15:0]        i_raw_humidity,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [14:0]      o_temperature_centi,
    output logic [24:0]             o_pressure_q8,
    output logic [16:0]             o_humidity_q10,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    import esc_pkg::*;

    // Calibration registers
    logic [47:0]        r_temp_calib;
    logic [63:0]        r_press_lo;
    logic [63:0]        r_press_hi;
    logic [15:0]        r_press_last;
    logic [63:0]        r_hum_calib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_lo   <= '0;
            r_press_hi   <= '0;
            r_press_last <= '0;
            r_hum_calib  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TEMP:       r_temp_calib <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_press_lo   <= i_cfg_data;
                CFG_PRESS_HIGH: r_press_hi   <= i_cfg_data;
                CFG_PRESS_LAST: r_press_last <= i_cfg_data[15:0];
                CFG_HUM:        r_hum_calib  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Unpack calibration fields
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = r_temp_calib[15:0];
    assign t2 = r_temp_calib[31:16];
    assign t3 = r_temp_calib[47:32];
    assign p1 = r_press_lo[15:0];
    assign p2 = r_press_lo[31:16];
    assign p3 = r_press_lo[47:32];
    assign p4 = r_press_lo[63:48];
    assign p5 = r_press_hi[15:0];
    assign p6 = r_press_hi[31:16];
    assign p7 = r_press_hi[47:32];
    assign p8 = r_press_hi[63:48];
    assign p9 = r_press_last;
    assign h1 = r_hum_calib[7:0];
    assign h2 = r_hum_calib[23:8];
    assign h3 = r_hum_calib[31:24];
    assign h4 = r_hum_calib[43:32];
    assign h5 = r_hum_calib[55:44];
    assign h6 = r_hum_calib[63:56];

    // Global advance: move when the output slot is free or being taken
    logic en;
    logic r_vld [1:LAT];

    assign en      = i_ready || !r_vld[LAT];
    assign o_ready = en;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_valid;
            for (int i = 2; i <= LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Raw value delay lines
    logic [19:0] r_pr_d [1:6];
    logic [15:0] r_hm_d [1:4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pr_d[1] <= i_raw_pressure;
            r_hm_d[1] <= i_raw_humidity;
            for (int i = 2; i <= 6; i++) r_pr_d[i] <= r_pr_d[i-1];
            for (int i = 2; i <= 4; i++) r_hm_d[i] <= r_hm_d[i-1];
        end
    end

    // Stages 1-4: temperature
    logic signed [20:0] r_s1_d;
    logic signed [36:0] r_s2_dt2;
    logic signed [41:0] r_s2_dd;
    logic signed [57:0] r_s3_n;
    logic signed [24:0] r_s4_tf;
    logic signed [14:0] r_tc_d [ST_TEMP:LAT];

    logic signed [60:0] tsum;
    logic signed [18:0] tcr;
    logic signed [24:0] n_s4_tf;
    logic signed [14:0] n_s4_tc;

    assign tsum = (61'(r_s3_n) <<< 2) + 61'(r_s3_n) + (61'sd1 <<< 41);
    assign tcr  = $signed(tsum[60:42]);
    assign n_s4_tf = r_s3_n[57] ? 25'(-((-r_s3_n) >>> 34)) : 25'(r_s3_n >>> 34);
    assign n_s4_tc = (tcr < -19'sd4000) ? -15'sd4000 :
                     (tcr > 19'sd8500)  ? 15'sd8500  : $signed(tcr[14:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d   <= $signed({1'b0, i_raw_temperature}) - $signed({1'b0, t1, 4'b0000});
            r_s2_dt2 <= 37'(r_s1_d) * 37'(t2);
            r_s2_dd  <= 42'(r_s1_d) * 42'(r_s1_d);
            r_s3_n   <= (58'(r_s2_dt2) <<< 20) + 58'(r_s2_dd) * 58'(t3);
            r_s4_tf  <= n_s4_tf;
            r_tc_d[ST_TEMP] <= n_s4_tc;
            for (int i = ST_TEMP + 1; i <= LAT; i++) r_tc_d[i] <= r_tc_d[i-1];
        end
    end

    // Stages 5-7: offsets, products and the pressure/humidity terms
    logic signed [25:0] r_s5_a, r_s5_b;
    logic signed [37:0] r_s5_yb, r_s6_yb;
    logic signed [49:0] r_s6_aa;
    logic signed [41:0] r_s6_p2a, r_s6_p5a;
    logic signed [37:0] r_s6_h5b;
    logic signed [34:0] r_s6_h3b, r_s6_h6b;
    logic signed [63:0] r_s7_inner, r_s7_x;
    logic signed [37:0] r_s7_y;
    logic signed [34:0] r_s7_v5, r_s7_h6b;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_a   <= 26'(r_s4_tf) - 26'sd128000;
            r_s5_b   <= 26'(r_s4_tf) - 26'sd76800;
            r_s5_yb  <= (38'($signed({1'b0, r_hm_d[4]})) <<< 14) - (38'(h4) <<< 20);
            r_s6_aa  <= 50'(r_s5_a) * 50'(r_s5_a);
            r_s6_p2a <= 42'(r_s5_a) * 42'(p2);
            r_s6_p5a <= 42'(r_s5_a) * 42'(p5);
            r_s6_h5b <= 38'(r_s5_b) * 38'(h5);
            r_s6_h3b <= 35'(r_s5_b) * 35'($signed({1'b0, h3}));
            r_s6_h6b <= 35'(r_s5_b) * 35'(h6);
            r_s6_yb  <= r_s5_yb;
            r_s7_inner <= (64'sd1 <<< 55) + 64'(r_s6_aa) * 64'(p3) + (64'(r_s6_p2a) <<< 20);
            r_s7_x   <= (((64'sd1 <<< 20) - 64'($signed({1'b0, r_pr_d[6]}))) <<< 31)
                        - (64'(r_s6_aa) * 64'(p6) + (64'(r_s6_p5a) <<< 17)
                           + (64'(p4) <<< 35));
            r_s7_y   <= r_s6_yb - r_s6_h5b;
            r_s7_v5  <= (35'sd1 <<< 26) + r_s6_h3b;
            r_s7_h6b <= r_s6_h6b;
        end
    end

    // Stage 8: divisor, numerator magnitude, humidity products
    logic               r_s8_bad, r_s8_xneg;
    logic [56:0]        r_s8_q;
    logic [62:0]        r_s8_xmag;
    logic signed [53:0] r_s8_yh2;
    logic signed [34:0] r_s8_v5;
    logic signed [63:0] r_s8_v6;
    logic [56:0]        qraw;

    assign qraw = 57'(p1) * 57'(r_s7_inner[62:23]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_bad  <= (p1 == 16'd0) || r_s7_inner[63] || (r_s7_inner == 64'sd0);
            r_s8_q    <= (qraw == 57'd0) ? 57'd1 : qraw;
            r_s8_xneg <= r_s7_x[63];
            r_s8_xmag <= r_s7_x[63] ? 63'(-r_s7_x) : 63'(r_s7_x);
            r_s8_yh2  <= 54'(r_s7_y) * 54'(h2);
            r_s8_v5   <= r_s7_v5;
            r_s8_v6   <= (64'sd1 <<< 52) + 64'(r_s7_h6b) * 64'(r_s7_v5);
        end
    end

    // Stage 9: scaled numerator, first humidity quotient split in halves
    logic [76:0]        r_s9_num;
    logic [56:0]        r_s9_q;
    logic               r_s9_bad, r_s9_xneg, r_s9_vs;
    logic [59:0]        r_s9_pl;
    logic [60:0]        r_s9_ph;
    logic signed [63:0] r_s9_v6;
    logic [52:0]        yh2m;
    logic [33:0]        v5m;

    assign yh2m = r_s8_yh2[53] ? 53'(-r_s8_yh2) : 53'(r_s8_yh2);
    assign v5m  = r_s8_v5[34] ? 34'(-r_s8_v5) : 34'(r_s8_v5);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s9_num  <= 77'(r_s8_xmag) * 77'(14'd12500);
            r_s9_q    <= r_s8_q;
            r_s9_bad  <= r_s8_bad;
            r_s9_xneg <= r_s8_xneg;
            r_s9_pl   <= 60'(yh2m[25:0]) * 60'(v5m);
            r_s9_ph   <= 61'(yh2m[52:26]) * 61'(v5m);
            r_s9_vs   <= r_s8_yh2[53] ^ r_s8_v5[34];
            r_s9_v6   <= r_s8_v6;
        end
    end

    // Stage 10: divider entry, overflow check; humidity quotient magnitude
    t_div_stage  r_div [0:DIV_STEPS];
    logic [61:0] r_s10_v1m;
    logic [62:0] r_s10_v6m;
    logic        r_s10_vs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0].ovf  <= 57'(r_s9_num[76:25]) >= r_s9_q;
            r_div[0].bad  <= r_s9_bad;
            r_div[0].xneg <= r_s9_xneg;
            r_div[0].den  <= r_s9_q;
            r_div[0].rem  <= 57'(r_s9_num[76:25]);
            r_div[0].lq   <= {r_s9_num[24:0], 16'd0};
            r_s10_v1m <= 62'(r_s9_ph) + 62'(r_s9_pl[59:26]);
            r_s10_v6m <= r_s9_v6[63] ? 63'(-r_s9_v6) : 63'(r_s9_v6);
            r_s10_vs  <= r_s9_vs ^ r_s9_v6[63];
        end
    end

    // Pressure divider: one restoring step per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DEN_W:0] rem_sh;
        logic           ge;
        logic [DEN_W:0] rem_sub;

        assign rem_sh  = {r_div[k].rem, r_div[k].lq[QUO_W-1]};
        assign ge      = rem_sh >= {1'b0, r_div[k].den};
        assign rem_sub = rem_sh - {1'b0, r_div[k].den};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k+1].ovf  <= r_div[k].ovf;
                r_div[k+1].bad  <= r_div[k].bad;
                r_div[k+1].xneg <= r_div[k].xneg;
                r_div[k+1].den  <= r_div[k].den;
                r_div[k+1].rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_div[k+1].lq   <= {r_div[k].lq[QUO_W-2:0], ge};
            end
        end
    end

    // Stages 11-16: humidity
    logic [63:0]        r_s11_ll;
    logic [62:0]        r_s11_lh;
    logic [61:0]        r_s11_hl;
    logic [60:0]        r_s11_hh;
    logic               r_s11_vs, r_s12_vs, r_s13_vs;
    logic [50:0]        r_s12_vm, r_s13_vm;
    logic [49:0]        r_s13_c11;
    logic [50:0]        r_s13_c10;
    logic [51:0]        r_s13_c00;
    logic [52:0]        r_s14_sq;
    logic signed [51:0] r_s14_v, r_s15_v;
    logic [60:0]        r_s15_hsq;
    logic [16:0]        r_hq_d [ST_HUM:LAT];

    logic [125:0]       vsum;
    logic [50:0]        n_s12_vm;
    logic [101:0]       vsq;
    logic signed [63:0] hum;
    logic [36:0]        hcl;
    logic [37:0]        hrnd;

    assign vsum = (126'(r_s11_hh) << 64) + (126'(r_s11_lh) << 32)
                + (126'(r_s11_hl) << 32) + 126'(r_s11_ll);
    assign n_s12_vm = (|vsum[125:102]) ? (51'd1 << 50) : 51'(vsum[101:52]);
    assign vsq = (102'(r_s13_c11) << 52) + (102'(r_s13_c10) << 27) + 102'(r_s13_c00);
    assign hum = 64'(r_s15_v) - $signed({3'b000, r_s15_hsq});
    assign hcl = hum[63] ? 37'd0 :
                 (hum > (64'sd100 <<< 30)) ? (37'd100 << 30) : hum[36:0];
    assign hrnd = 38'(hcl) + (38'd1 << 19);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s11_ll  <= 64'(r_s10_v1m[31:0]) * 64'(r_s10_v6m[31:0]);
            r_s11_lh  <= 63'(r_s10_v1m[31:0]) * 63'(r_s10_v6m[62:32]);
            r_s11_hl  <= 62'(r_s10_v1m[61:32]) * 62'(r_s10_v6m[31:0]);
            r_s11_hh  <= 61'(r_s10_v1m[61:32]) * 61'(r_s10_v6m[62:32]);
            r_s11_vs  <= r_s10_vs;
            r_s12_vm  <= n_s12_vm;
            r_s12_vs  <= r_s11_vs;
            r_s13_c11 <= 50'(r_s12_vm[50:26]) * 50'(r_s12_vm[50:26]);
            r_s13_c10 <= 51'(r_s12_vm[50:26]) * 51'(r_s12_vm[25:0]);
            r_s13_c00 <= 52'(r_s12_vm[25:0]) * 52'(r_s12_vm[25:0]);
            r_s13_vm  <= r_s12_vm;
            r_s13_vs  <= r_s12_vs;
            r_s14_sq  <= vsq[101:49];
            r_s14_v   <= r_s13_vs ? -$signed({1'b0, r_s13_vm}) : $signed({1'b0, r_s13_vm});
            r_s15_hsq <= 61'(r_s14_sq) * 61'(h1);
            r_s15_v   <= r_s14_v;
            r_hq_d[ST_HUM] <= hrnd[36:20];
            for (int i = ST_HUM + 1; i <= LAT; i++) r_hq_d[i] <= r_hq_d[i-1];
        end
    end

    // Stages 52-56: pressure corrections, rounding and clamp
    logic [40:0]        r_s52_p0m;
    logic signed [41:0] r_s52_p0, r_s53_p0, r_s54_p0, r_s55_p0;
    logic               r_s52_bad, r_s53_bad, r_s54_bad, r_s55_bad;
    logic [41:0]        r_s53_e11;
    logic [40:0]        r_s53_e10;
    logic [39:0]        r_s53_e00;
    logic signed [57:0] r_s53_p8t, r_s54_p8t, r_s55_p8t;
    logic [45:0]        r_s54_sq;
    logic signed [62:0] r_s55_p9t;
    logic [24:0]        r_s56_pq8;

    logic [40:0]        quo;
    logic [40:0]        n_s52_p0m;
    logic [81:0]        psq;
    logic signed [63:0] pq16, pq8r;
    logic [24:0]        n_s56_pq8;

    assign quo = r_div[DIV_STEPS].lq;
    assign n_s52_p0m = (r_div[DIV_STEPS].ovf || quo > (41'd1 << 40)) ? (41'd1 << 40) : quo;
    assign psq = (82'(r_s53_e11) << 40) + (82'(r_s53_e10) << 21) + 82'(r_s53_e00);
    assign pq16 = 64'(r_s55_p0) + 64'(r_s55_p9t >>> 15) + 64'(r_s55_p8t >>> 19)
                + (64'(p7) <<< 12);
    assign pq8r = (pq16 + 64'sd128) >>> 8;
    assign n_s56_pq8 = (r_s55_bad || pq8r < 64'sd7680000) ? 25'd7680000 :
                       (pq8r > 64'sd28160000) ? 25'd28160000 : pq8r[24:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s52_p0m <= n_s52_p0m;
            r_s52_p0  <= r_div[DIV_STEPS].xneg ? -$signed({1'b0, n_s52_p0m})
                                               : $signed({1'b0, n_s52_p0m});
            r_s52_bad <= r_div[DIV_STEPS].bad;
            r_s53_e11 <= 42'(r_s52_p0m[40:20]) * 42'(r_s52_p0m[40:20]);
            r_s53_e10 <= 41'(r_s52_p0m[40:20]) * 41'(r_s52_p0m[19:0]);
            r_s53_e00 <= 40'(r_s52_p0m[19:0]) * 40'(r_s52_p0m[19:0]);
            r_s53_p8t <= 58'(r_s52_p0) * 58'(p8);
            r_s53_p0  <= r_s52_p0;
            r_s53_bad <= r_s52_bad;
            r_s54_sq  <= psq[81:36];
            r_s54_p0  <= r_s53_p0;
            r_s54_p8t <= r_s53_p8t;
            r_s54_bad <= r_s53_bad;
            r_s55_p9t <= 63'($signed({1'b0, r_s54_sq})) * 63'(p9);
            r_s55_p0  <= r_s54_p0;
            r_s55_p8t <= r_s54_p8t;
            r_s55_bad <= r_s54_bad;
            r_s56_pq8 <= n_s56_pq8;
        end
    end

    // Output register
    assign o_temperature_centi = r_tc_d[LAT];
    assign o_pressure_q8       = r_s56_pq8;
    assign o_humidity_q10      = r_hq_d[LAT];

endmodule

`default_nettype wire

// ----- tb/tb_env_sensor_compensation.sv -----
`default_nettype none

module tb_env_sensor_compensation;
    import esc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [14:0] temp;
        logic [24:0]        press;
        logic [16:0]        hum;
    } reading_out_t;

    typedef struct {
        logic         is_cfg;
        logic [2:0]   idx;
        logic [63:0]  data;
        logic [19:0]  raw_t;
        logic [19:0]  raw_p;
        logic [15:0]  raw_h;
        logic         typed;
        reading_out_t want;
    } stim_row_t;

    // Index past the end of the register list; writes there are dropped
    localparam logic [2:0]  CFG_NONE   = 3'd5;
    localparam logic [47:0] TEMP_TYP   = 48'hFC18_6743_6B70;
    localparam logic [63:0] PLOW_TYP   = 64'h0B27_0BD0_D643_8E7D;
    localparam logic [63:0] PHIGH_TYP  = 64'hC6F8_3C8C_FFF9_008C;
    localparam logic [15:0] P9_TYP     = 16'h1770;
    localparam logic [63:0] HUM_TYP    = 64'h1E03_2139_0001_6A4B;
    localparam logic [24:0] PRESS_MIN  = 25'd7680000;
    localparam logic [24:0] PRESS_MAX  = 25'd28160000;
    localparam int          RAND_ITEMS = 1700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic [15:0] i_raw_humidity = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [14:0] o_temperature_centi;
    logic [24:0] o_pressure_q8;
    logic [16:0] o_humidity_q10;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    env_sensor_compensation u_top (.*);

    always #1 i_clk = ~i_clk;

    // Calibration mirror
    logic [47:0] cal_temp;
    logic [63:0] cal_plow;
    logic [63:0] cal_phigh;
    logic [15:0] cal_p9;
    logic [63:0] cal_hum;

    reading_out_t pending_readings[$];
    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int n_items;
    int n_results;
    int n_cfg;

    function automatic wide_t wabs(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    // |x*y|/dv truncated, magnitude capped, sign of the product
    function automatic wide_t scaled_product(wide_t x, wide_t y, wide_t dv, wide_t cap);
        wide_t m;
        m = wabs(x) * wabs(y) / dv;
        if (m > cap) m = cap;
        if ((x < 0) != (y < 0)) m = -m;
        return m;
    endfunction

    function automatic logic [16:0] hum_round(wide_t hum);
        wide_t t;
        t = (hum + (wide_t'(1) << 19)) >>> 20;
        return t[16:0];
    endfunction

    function automatic reading_out_t compensate(logic [19:0] rt, logic [19:0] rp,
                                                logic [15:0] rh);
        wide_t one, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        wide_t h1, h2, h3, h4, h5, h6;
        wide_t d, n, tf, tc, a, inner, q, x, p0, sq, pq16, pq8;
        wide_t b, y, v5, v6, v, hum;
        reading_out_t r;
        one = 1;
        t1 = cal_temp[15:0];   t2 = $signed(cal_temp[31:16]);
        t3 = $signed(cal_temp[47:32]);
        p1 = cal_plow[15:0];   p2 = $signed(cal_plow[31:16]);
        p3 = $signed(cal_plow[47:32]);  p4 = $signed(cal_plow[63:48]);
        p5 = $signed(cal_phigh[15:0]);  p6 = $signed(cal_phigh[31:16]);
        p7 = $signed(cal_phigh[47:32]); p8 = $signed(cal_phigh[63:48]);
        p9 = $signed(cal_p9);
        h1 = cal_hum[7:0];     h2 = $signed(cal_hum[23:8]);
        h3 = cal_hum[31:24];   h4 = $signed(cal_hum[43:32]);
        h5 = $signed(cal_hum[55:44]);   h6 = $signed(cal_hum[63:56]);

        // Temperature and fine temperature
        d  = wide_t'(rt) - 16 * t1;
        n  = d * t2 * (one << 20) + d * d * t3;
        tf = n / (one << 34);
        tc = (5 * n + (one << 41)) >>> 42;
        if (tc < -4000) tc = -4000;
        else if (tc > 8500) tc = 8500;

        // Pressure
        a = tf - 128000;
        inner = (one << 55) + p3 * a * a + p2 * a * (one << 20);
        if (p1 == 0 || inner <= 0) begin
            pq8 = PRESS_MIN;
        end else begin
            q = p1 * (inner >>> 23);
            if (q == 0) q = 1;
            x = ((one << 20) - wide_t'(rp)) * (one << 31)
                - (p6 * a * a + p5 * a * (one << 17) + p4 * (one << 35));
            p0 = scaled_product(x, 12500 * 65536, q, one << 40);
            sq = scaled_product(p0, p0, one << 36, one << 62);
            pq16 = p0 + ((p9 * sq) >>> 15) + ((p0 * p8) >>> 19) + p7 * 4096;
            pq8 = (pq16 + 128) >>> 8;
            if (pq8 < wide_t'(PRESS_MIN)) pq8 = PRESS_MIN;
            else if (pq8 > wide_t'(PRESS_MAX)) pq8 = PRESS_MAX;
        end

        // Humidity
        b  = tf - 76800;
        y  = wide_t'(rh) * 16384 - h4 * (one << 20) - h5 * b;
        v5 = (one << 26) + h3 * b;
        v6 = (one << 52) + h6 * b * v5;
        v  = scaled_product(y * h2, v5, one << 26, one << 62);
        v  = scaled_product(v, v6, one << 52, one << 50);
        hum = v - h1 * scaled_product(v, v, one << 49, one << 62);
        if (hum < 0) hum = 0;
        else if (hum > (wide_t'(100) << 30)) hum = wide_t'(100) << 30;

        r.temp  = tc[14:0];
        r.press = pq8[24:0];
        r.hum   = hum_round(hum);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    endtask

    // Hold until every expected reading is back and the pipeline has drained
    task automatic wait_drained();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TEMP:       cal_temp  = data[47:0];
            CFG_PRESS_LOW:  cal_plow  = data;
            CFG_PRESS_HIGH: cal_phigh = data;
            CFG_PRESS_LAST: cal_p9    = data[15:0];
            CFG_HUM:        cal_hum   = data;
            default: ;
        endcase
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure    <= rp;
        i_raw_humidity    <= rh;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_readings.push_back(compensate(rt, rp, rh));
        n_items++;
    endtask

    task automatic random_calibration();
        logic [63:0] w;
        bit typical;
        typical = 1'($urandom_range(1));
        w = {$urandom, $urandom};
        write_cfg(CFG_TEMP, typical ? {16'h0, TEMP_TYP ^ (w[47:0] & 48'h00FF_03FF_00FF)} : w);
        w = {$urandom, $urandom};
        write_cfg(CFG_PRESS_LOW, typical ? PLOW_TYP ^ (w & 64'h00FF_00FF_03FF_00FF) : w);
        w = {$urandom, $urandom};
        write_cfg(CFG_PRESS_HIGH, typical ? PHIGH_TYP ^ (w & 64'h03FF_03FF_000F_003F) : w);
        w = {$urandom, $urandom};
        write_cfg(CFG_PRESS_LAST, typical ? {48'h0, P9_TYP ^ (w[15:0] & 16'h03FF)} : w);
        w = {$urandom, $urandom};
        write_cfg(CFG_HUM, typical ? HUM_TYP ^ (w & 64'h0700_7007_0003_0F0F) : w);
    endtask

    // Check each returned reading and drive the receiver's ready
    always @(posedge i_clk) begin
        reading_out_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected reading", 0, 0);
            end else begin
                e = pending_readings.pop_front();
                if (o_temperature_centi !== e.temp)
                    report_mismatch("temperature_centi", o_temperature_centi, e.temp);
                if (o_pressure_q8 !== e.press)
                    report_mismatch("pressure_q8", o_pressure_q8, e.press);
                if (o_humidity_q10 !== e.hum)
                    report_mismatch("humidity_q10", o_humidity_q10, e.hum);
            end
            n_results++;
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        stim_row_t dir_tab[$];
        stim_row_t row;
        reading_out_t got;
        int k;
        int phase;
        int pause_at;
        int send_pcts[4];
        int recv_pcts[4];

        send_pcts = '{0, 88, 0, 36};
        recv_pcts = '{0, 0, 88, 36};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0; n_items = 0; n_results = 0; n_cfg = 0;
        cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_p9 = '0; cal_hum = '0;

        dir_tab = '{
            // Reset calibration: zero temperature, minimum pressure, zero humidity
            '{0, CFG_NONE, 0, 20'h00000, 20'h00000, 16'h0000, 1, '{0, PRESS_MIN, 0}},
            '{0, CFG_NONE, 0, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, '{0, PRESS_MIN, 0}},
            '{0, CFG_NONE, 0, 20'h80000, 20'h5A5A5, 16'hA5A5, 1, '{0, PRESS_MIN, 0}},
            // Write past the register list is dropped
            '{1, CFG_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h12345, 20'h54321, 16'h1234, 1, '{0, PRESS_MIN, 0}},
            // Typical calibration
            '{1, CFG_TEMP, {16'h0, TEMP_TYP}, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_PRESS_LOW, PLOW_TYP, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_PRESS_HIGH, PHIGH_TYP, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_PRESS_LAST, {48'h0, P9_TYP}, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_HUM, HUM_TYP, 0, 0, 0, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h7E8F0, 20'h5D0C0, 16'h6A3C, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h00000, 20'h5D0C0, 16'h6A3C, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'hFFFFF, 20'h5D0C0, 16'h6A3C, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h7E8F0, 20'h00000, 16'h0000, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h7E8F0, 20'hFFFFF, 16'hFFFF, 0, '{0, 0, 0}},
            // Unity p1 with flat terms: uncorrected pressure saturates
            '{1, CFG_PRESS_LOW, 64'h0B27_0000_0000_0001, 0, 0, 0, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h7E8F0, 20'h00000, 16'h8000, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h7E8F0, 20'hFFFFF, 16'h8000, 0, '{0, 0, 0}},
            // All-ones, max-positive and most-negative calibration words
            '{1, CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_PRESS_LOW, 64'h7FFF_7FFF_7FFF_FFFF, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_PRESS_LAST, 64'h0000_0000_0000_8000, 0, 0, 0, 0, '{0, 0, 0}},
            '{1, CFG_HUM, 64'h7F7F_F7FF_FF7F_FFFF, 0, 0, 0, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'hFFFFF, 20'h00000, 16'hFFFF, 0, '{0, 0, 0}},
            '{0, CFG_NONE, 0, 20'h00000, 20'hFFFFF, 16'h0000, 0, '{0, 0, 0}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_tab[k]) begin
            row = dir_tab[k];
            if (row.is_cfg) begin
                write_cfg(row.idx, row.data);
            end else begin
                send_reading(row.raw_t, row.raw_p, row.raw_h);
                if (row.typed) begin
                    got = pending_readings[$];
                    if (got.temp !== row.want.temp || got.press !== row.want.press ||
                        got.hum !== row.want.hum)
                        report_mismatch("table row prediction", k, k);
                    pending_readings[$] = row.want;
                end
            end
        end
        i_valid <= 1'b0;

        // Random readings over idle/stall phases and calibration sets
        pause_at = $urandom_range(100, 300);
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            for (k = 0; k < RAND_ITEMS / 4; k++) begin
                if (k % 85 == 0) begin
                    i_valid <= 1'b0;
                    random_calibration();
                end
                if (phase == 1 && k == pause_at) begin
                    i_valid <= 1'b0;
                    while (pending_readings.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(3) == 0)
                    send_reading(20'($urandom), 20'($urandom), 16'($urandom));
                else
                    send_reading(20'd16 * cal_temp[15:0] + 20'($urandom_range(0, 65535))
                                 - 20'd32768,
                                 20'($urandom_range(200000, 700000)), 16'($urandom));
            end
            i_valid <= 1'b0;
        end

        wait_drained();
        $display("Covered %0d readings, %0d results, %0d register writes", n_items,
                 n_results, n_cfg);
        $display("over four idle/stall phases with typical, random and extreme calibration");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
